### sv/pee_pkg.sv
// Shared types, widths, stage numbers and tables for the point elastic energy block.
package pee_pkg;

  localparam int F_W = 32;
  localparam int F_FRAC = 28;
  localparam int VOL_W = 32;
  localparam int Q_W = 64;
  localparam int YM_W = 32;
  localparam int PR_W = 15;
  localparam int KV_W = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam int S_ONE = 65536;
  localparam int SV_W = 17;
  localparam int K_SHIFT = 20;
  localparam int K_W = YM_W + K_SHIFT;
  localparam int DIV_W = 33;

  localparam int EACC_W = 2 * F_W + 2;
  localparam int E_W = EACC_W - F_FRAC;
  localparam int COF_W = 2 * F_W + 1;
  localparam int M_W = 56;
  localparam int N_W = 110;
  localparam int DET_W = 100;
  localparam int DET_SHIFT = 52;
  localparam int DET_ONE_SHIFT = 84;
  localparam int D_W = DET_W - DET_SHIFT;
  localparam int VT_SHIFT = 33;
  localparam int VT_W = 90;
  localparam int SE_W = 101;
  localparam int SUM3_W = SE_W + 2;
  localparam int ACC_W = SUM3_W + 2;
  localparam int ACC_SHIFT = 9;
  localparam int EL_SHIFT = 44;
  localparam int EL_W = 84;
  localparam int TOT_W = 92;

  localparam int LIMB_W = 32;
  localparam int MA_W = 3 * LIMB_W;
  localparam int MB_W = 2 * LIMB_W;
  localparam int MP_W = MA_W + MB_W;
  localparam int PP_W = 2 * LIMB_W + 2;
  localparam int MUL_LAT = 3;

  localparam int DIV_STEP = 4;
  localparam int DIV_STAGES = Q_W / DIV_STEP;
  localparam int DIV_LAT = DIV_STAGES + 2;

  localparam int ST_E = 2;
  localparam int ST_M = ST_E + 1;
  localparam int ST_DET = ST_E + MUL_LAT;
  localparam int ST_D = ST_DET + 1;
  localparam int ST_DD = ST_D + MUL_LAT;
  localparam int ST_VT = ST_DD + MUL_LAT;
  localparam int ST_MK = ST_M + MUL_LAT;
  localparam int ST_S = ST_MK + DIV_LAT;
  localparam int ST_SE = ST_S + MUL_LAT;
  localparam int ST_AB = ST_SE + 1;
  localparam int ST_ACC = ST_AB + 1;
  localparam int ST_EL = ST_ACC + MUL_LAT;
  localparam int ST_OUT = ST_EL + 1;

  localparam int E_DLY = ST_S - ST_E;
  localparam int F0_DLY = ST_E;
  localparam int VOL_DLY = ST_ACC;
  localparam int VT_DLY = ST_EL - ST_VT;
  localparam int S_DLY = ST_EL - ST_S;

  localparam int IX_XX = 0;
  localparam int IX_YY = 1;
  localparam int IX_ZZ = 2;
  localparam int IX_XY = 3;
  localparam int IX_YZ = 4;
  localparam int IX_XZ = 5;
  localparam int N_ENT = 6;
  localparam int N_DIAG = 3;

  localparam int ROW [N_ENT] = '{0, 1, 2, 0, 1, 0};
  localparam int COL [N_ENT] = '{0, 1, 2, 1, 2, 2};
  localparam int NXT1 [N_DIAG] = '{1, 2, 0};
  localparam int NXT2 [N_DIAG] = '{2, 0, 1};

  localparam logic [CFG_IDX_W-1:0] CFG_YOUNG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POISSON = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KV = 2'd2;

  localparam logic [YM_W-1:0] YOUNG_RST = 32'd1000000;
  localparam logic [PR_W-1:0] POISSON_RST = 15'd19661;
  localparam logic [KV_W-1:0] KV_RST = 32'd0;

  localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W - 1){1'b1}}};
  localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W - 1){1'b0}}};

  typedef struct packed {
    logic signed [F_W-1:0] f_00;
    logic signed [F_W-1:0] f_01;
    logic signed [F_W-1:0] f_02;
    logic signed [F_W-1:0] f_10;
    logic signed [F_W-1:0] f_11;
    logic signed [F_W-1:0] f_12;
    logic signed [F_W-1:0] f_20;
    logic signed [F_W-1:0] f_21;
    logic signed [F_W-1:0] f_22;
    logic [VOL_W-1:0] point_volume;
  } in_item_t;

  typedef struct packed {
    logic signed [Q_W-1:0] energy;
    logic signed [Q_W-1:0] stress_xx;
    logic signed [Q_W-1:0] stress_yy;
    logic signed [Q_W-1:0] stress_zz;
    logic signed [Q_W-1:0] stress_xy;
    logic signed [Q_W-1:0] stress_yz;
    logic signed [Q_W-1:0] stress_xz;
  } out_item_t;

  typedef struct packed {
    logic [PR_W-1:0] v;
    logic [SV_W-1:0] s_minus_v;
    logic [SV_W-1:0] s_minus_2v;
  } elastic_cfg_t;

  typedef logic signed [E_W-1:0] strain_t [N_ENT];
  typedef logic signed [M_W-1:0] mvec_t [N_ENT];
  typedef logic signed [COF_W-1:0] cof_t [N_DIAG];
  typedef logic signed [F_W-1:0] fcol_t [N_DIAG];
  typedef logic signed [Q_W-1:0] stress_t [N_ENT];

endpackage

### sv/pee_mul.sv
// Three-stage signed 96 by 64 bit multiplier built from 33 by 33 bit partial products.
module pee_mul
  import pee_pkg::*;
(
  input  logic                   clk,
  input  logic signed [MA_W-1:0] a,
  input  logic signed [MB_W-1:0] b,
  output logic signed [MP_W-1:0] p
);

  logic signed [LIMB_W:0] al [3];
  logic signed [LIMB_W:0] bl [2];
  logic signed [PP_W-1:0] pp [3][2];
  logic signed [MP_W-1:0] t [2];

  always_comb begin
    al[0] = $signed({1'b0, a[LIMB_W-1:0]});
    al[1] = $signed({1'b0, a[2*LIMB_W-1:LIMB_W]});
    al[2] = $signed({a[MA_W-1], a[MA_W-1:2*LIMB_W]});
    bl[0] = $signed({1'b0, b[LIMB_W-1:0]});
    bl[1] = $signed({b[MB_W-1], b[MB_W-1:LIMB_W]});
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 2; j++) begin
        pp[i][j] <= al[i] * bl[j];
      end
    end
    for (int j = 0; j < 2; j++) begin
      t[j] <= MP_W'(pp[0][j]) + (MP_W'(pp[1][j]) <<< LIMB_W)
            + (MP_W'(pp[2][j]) <<< (2 * LIMB_W));
    end
    p <= t[0] + (t[1] <<< LIMB_W);
  end

endmodule

### sv/pee_div.sv
// Pipelined signed divider by a configuration constant, truncating, saturated to 64 bits.
module pee_div
  import pee_pkg::*;
(
  input  logic                  clk,
  input  logic signed [N_W-1:0] n,
  input  logic [DIV_W-1:0]      d,
  output logic signed [Q_W-1:0] q
);

  logic [N_W-1:0]   mag;
  logic [DIV_W-1:0] rem [DIV_STAGES+1];
  logic [Q_W-1:0]   low [DIV_STAGES+1];
  logic             neg [DIV_STAGES+1];
  logic             ovf [DIV_STAGES+1];

  function automatic logic [DIV_W+Q_W-1:0] div_step(input logic [DIV_W-1:0] r_in,
                                                    input logic [Q_W-1:0] l_in,
                                                    input logic [DIV_W-1:0] dv);
    logic [DIV_W:0]   trial;
    logic [DIV_W-1:0] r;
    logic [Q_W-1:0]   l;
    r = r_in;
    l = l_in;
    for (int k = 0; k < DIV_STEP; k++) begin
      trial = {r, l[Q_W-1]};
      l = {l[Q_W-2:0], 1'b0};
      if (trial >= {1'b0, dv}) begin
        trial = trial - {1'b0, dv};
        l[0] = 1'b1;
      end
      r = trial[DIV_W-1:0];
    end
    return {r, l};
  endfunction

  always_comb begin
    mag = n[N_W-1] ? N_W'(-n) : N_W'(n);
  end

  always_ff @(posedge clk) begin
    neg[0] <= n[N_W-1];
    ovf[0] <= mag[N_W-1:Q_W-1] >= (N_W - Q_W + 1)'(d);
    rem[0] <= mag[Q_W+DIV_W-1:Q_W];
    low[0] <= mag[Q_W-1:0];
    for (int s = 0; s < DIV_STAGES; s++) begin
      {rem[s+1], low[s+1]} <= div_step(rem[s], low[s], d);
      neg[s+1] <= neg[s];
      ovf[s+1] <= ovf[s];
    end
    if (ovf[DIV_STAGES]) begin
      q <= neg[DIV_STAGES] ? Q_MIN : Q_MAX;
    end else begin
      q <= neg[DIV_STAGES] ? -low[DIV_STAGES] : low[DIV_STAGES];
    end
  end

endmodule

### sv/pee_front.sv
// Front stages: strain products and sums, determinant cofactors, and stress numerators.
module pee_front
  import pee_pkg::*;
(
  input  logic         clk,
  input  in_item_t     item,
  input  elastic_cfg_t ecfg,
  output strain_t      e,
  output cof_t         cof,
  output fcol_t        f0,
  output mvec_t        m
);

  logic signed [F_W-1:0]    fm [3][3];
  logic signed [2*F_W-1:0]  sprod [N_ENT][3];
  logic signed [2*F_W-1:0]  dprod [N_ENT];
  logic signed [F_W-1:0]    f0_r1 [N_DIAG];
  logic signed [EACC_W-1:0] esum [N_ENT];
  logic signed [M_W-1:0]    mcomb [N_ENT];
  logic signed [M_W-1:0]    smv_s;
  logic signed [M_W-1:0]    s2v_s;
  logic signed [M_W-1:0]    v_s;

  always_comb begin
    fm[0][0] = item.f_00;
    fm[0][1] = item.f_01;
    fm[0][2] = item.f_02;
    fm[1][0] = item.f_10;
    fm[1][1] = item.f_11;
    fm[1][2] = item.f_12;
    fm[2][0] = item.f_20;
    fm[2][1] = item.f_21;
    fm[2][2] = item.f_22;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N_ENT; i++) begin
      for (int k = 0; k < 3; k++) begin
        sprod[i][k] <= fm[k][ROW[i]] * fm[k][COL[i]];
      end
    end
    dprod[0] <= fm[1][1] * fm[2][2];
    dprod[1] <= fm[1][2] * fm[2][1];
    dprod[2] <= fm[1][0] * fm[2][2];
    dprod[3] <= fm[1][2] * fm[2][0];
    dprod[4] <= fm[1][0] * fm[2][1];
    dprod[5] <= fm[1][1] * fm[2][0];
    for (int k = 0; k < N_DIAG; k++) begin
      f0_r1[k] <= fm[0][k];
    end
  end

  always_comb begin
    for (int i = 0; i < N_ENT; i++) begin
      esum[i] = EACC_W'(sprod[i][0]) + EACC_W'(sprod[i][1]) + EACC_W'(sprod[i][2]);
      if (i < N_DIAG) begin
        esum[i] = esum[i] - (EACC_W'(1) <<< (2 * F_FRAC));
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N_ENT; i++) begin
      e[i] <= esum[i][EACC_W-1:F_FRAC];
    end
    cof[0] <= COF_W'(dprod[0]) - COF_W'(dprod[1]);
    cof[1] <= COF_W'(dprod[2]) - COF_W'(dprod[3]);
    cof[2] <= COF_W'(dprod[4]) - COF_W'(dprod[5]);
    f0 <= f0_r1;
  end

  assign smv_s = M_W'($signed({1'b0, ecfg.s_minus_v}));
  assign s2v_s = M_W'($signed({1'b0, ecfg.s_minus_2v}));
  assign v_s = M_W'($signed({1'b0, ecfg.v}));

  always_comb begin
    for (int i = 0; i < N_ENT; i++) begin
      if (i < N_DIAG) begin
        mcomb[i] = smv_s * M_W'(e[i])
                 + v_s * (M_W'(e[NXT1[i]]) + M_W'(e[NXT2[i]]));
      end else begin
        mcomb[i] = s2v_s * M_W'(e[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    m <= mcomb;
  end

endmodule

### sv/point_elastic_energy.sv
// Top level of the point elastic energy block: configuration, pipeline and result register.
// One point is accepted in every cycle; busy stays low and the receiver cannot stall, so the
// result of each accepted item appears with done high. The latency is set mostly by the
// stress dividers, which form 64 quotient bits at four per stage, and by the three-stage
// wide multipliers that follow one another along the energy path.
module point_elastic_energy
  import pee_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              item,
  output logic                  done,
  output out_item_t             result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [YM_W-1:0]  young;
  logic [PR_W-1:0]  poisson;
  logic [KV_W-1:0]  kv;
  elastic_cfg_t     ecfg;
  logic [DIV_W-1:0] div_d;
  logic [K_W-1:0]   k_mul;

  logic [ST_OUT:0] vld;
  in_item_t        in_r;

  strain_t e;
  cof_t    cof;
  fcol_t   f0;
  mvec_t   m;

  logic signed [MP_W-1:0] det_p [N_DIAG];
  logic signed [DET_W-1:0] det_sum;
  logic signed [D_W-1:0]   d_r;
  logic signed [MP_W-1:0] dd_p;
  logic signed [MP_W-1:0] vt_p;
  logic signed [MB_W-1:0] kv_b;
  logic signed [MB_W-1:0] k_b;
  logic signed [MP_W-1:0] mk_p [N_ENT];
  stress_t                s;
  logic signed [MP_W-1:0] se_p [N_ENT];
  logic signed [SUM3_W-1:0] sum_diag;
  logic signed [SUM3_W-1:0] sum_off;
  logic signed [ACC_W-1:0]  acc;
  logic signed [MA_W-1:0]   acc9;
  logic signed [MB_W-1:0]   vol_b;
  logic signed [MP_W-1:0]   el_p;
  logic signed [TOT_W-1:0]  total;

  strain_t         e_line [E_DLY];
  logic [VOL_W-1:0] vol_line [VOL_DLY];
  logic [VT_W-1:0]  vt_line [VT_DLY];
  stress_t         s_line [S_DLY];

  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [TOT_W-1:0] x);
    logic signed [Q_W-1:0] r;
    if (x[TOT_W-1:Q_W-1] == '0 || x[TOT_W-1:Q_W-1] == '1) begin
      r = x[Q_W-1:0];
    end else if (x[TOT_W-1]) begin
      r = Q_MIN;
    end else begin
      r = Q_MAX;
    end
    return r;
  endfunction

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;
  assign done = vld[ST_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      young <= YOUNG_RST;
      poisson <= POISSON_RST;
      kv <= KV_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_YOUNG: young <= cfg_data[YM_W-1:0];
        CFG_POISSON: poisson <= cfg_data[PR_W-1:0];
        CFG_KV: kv <= cfg_data[KV_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    ecfg.v <= poisson;
    ecfg.s_minus_v <= SV_W'(S_ONE) - SV_W'(poisson);
    ecfg.s_minus_2v <= SV_W'(S_ONE) - SV_W'({poisson, 1'b0});
    div_d <= DIV_W'(SV_W'(S_ONE) + SV_W'(poisson))
           * DIV_W'(SV_W'(S_ONE) - SV_W'({poisson, 1'b0}));
    k_mul <= {young, {K_SHIFT{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[ST_OUT-1:0], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    in_r <= item;
  end

  pee_front u_front (
    .clk  (clk),
    .item (in_r),
    .ecfg (ecfg),
    .e    (e),
    .cof  (cof),
    .f0   (f0),
    .m    (m)
  );

  // Volume penalty path.
  for (genvar g = 0; g < N_DIAG; g++) begin : g_det
    pee_mul u_mul (
      .clk (clk),
      .a   (MA_W'(cof[g])),
      .b   (MB_W'(f0[g])),
      .p   (det_p[g])
    );
  end

  assign det_sum = DET_W'(det_p[0]) - DET_W'(det_p[1]) + DET_W'(det_p[2])
                 - (DET_W'(1) <<< DET_ONE_SHIFT);

  always_ff @(posedge clk) begin
    d_r <= det_sum[DET_W-1:DET_SHIFT];
  end

  pee_mul u_dd (
    .clk (clk),
    .a   (MA_W'(d_r)),
    .b   (MB_W'(d_r)),
    .p   (dd_p)
  );

  assign kv_b = $signed({{(MB_W - KV_W){1'b0}}, kv});

  pee_mul u_vt (
    .clk (clk),
    .a   ($signed(dd_p[MA_W-1:0])),
    .b   (kv_b),
    .p   (vt_p)
  );

  // Stress path.
  assign k_b = $signed({{(MB_W - K_W){1'b0}}, k_mul});

  for (genvar g = 0; g < N_ENT; g++) begin : g_stress
    pee_mul u_mul (
      .clk (clk),
      .a   (MA_W'(m[g])),
      .b   (k_b),
      .p   (mk_p[g])
    );
    pee_div u_div (
      .clk (clk),
      .n   ($signed(mk_p[g][N_W-1:0])),
      .d   (div_d),
      .q   (s[g])
    );
    pee_mul u_se (
      .clk (clk),
      .a   (MA_W'(s[g])),
      .b   (MB_W'(e_line[E_DLY-1][g])),
      .p   (se_p[g])
    );
  end

  // Elastic energy path.
  always_ff @(posedge clk) begin
    sum_diag <= SUM3_W'(se_p[IX_XX]) + SUM3_W'(se_p[IX_YY]) + SUM3_W'(se_p[IX_ZZ]);
    sum_off <= SUM3_W'(se_p[IX_XY]) + SUM3_W'(se_p[IX_YZ]) + SUM3_W'(se_p[IX_XZ]);
  end

  assign acc = ACC_W'(sum_diag) + (ACC_W'(sum_off) <<< 1);

  always_ff @(posedge clk) begin
    acc9 <= acc[ACC_W-1:ACC_SHIFT];
  end

  assign vol_b = $signed({{(MB_W - VOL_W){1'b0}}, vol_line[VOL_DLY-1]});

  pee_mul u_el (
    .clk (clk),
    .a   (acc9),
    .b   (vol_b),
    .p   (el_p)
  );

  // Delay lines that keep operands aligned with the pipeline.
  always_ff @(posedge clk) begin
    e_line[0] <= e;
    for (int k = 1; k < E_DLY; k++) begin
      e_line[k] <= e_line[k-1];
    end
    vol_line[0] <= in_r.point_volume;
    for (int k = 1; k < VOL_DLY; k++) begin
      vol_line[k] <= vol_line[k-1];
    end
    vt_line[0] <= vt_p[VT_SHIFT+VT_W-1:VT_SHIFT];
    for (int k = 1; k < VT_DLY; k++) begin
      vt_line[k] <= vt_line[k-1];
    end
    s_line[0] <= s;
    for (int k = 1; k < S_DLY; k++) begin
      s_line[k] <= s_line[k-1];
    end
  end

  assign total = TOT_W'($signed(el_p[EL_SHIFT+EL_W-1:EL_SHIFT]))
               + TOT_W'($signed({1'b0, vt_line[VT_DLY-1]}));

  always_ff @(posedge clk) begin
    result.energy <= sat_q(total);
    result.stress_xx <= s_line[S_DLY-1][IX_XX];
    result.stress_yy <= s_line[S_DLY-1][IX_YY];
    result.stress_zz <= s_line[S_DLY-1][IX_ZZ];
    result.stress_xy <= s_line[S_DLY-1][IX_XY];
    result.stress_yz <= s_line[S_DLY-1][IX_YZ];
    result.stress_xz <= s_line[S_DLY-1][IX_XZ];
  end

endmodule

### bench/point_elastic_energy_test.sv
// Self-checking testbench for the point elastic energy block with a built-in scoreboard.
module point_elastic_energy_test
  import pee_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;

  class energy_scoreboard;
    out_item_t expected_q[$];
    logic [YM_W-1:0] young = YOUNG_RST;
    logic [PR_W-1:0] poisson = POISSON_RST;
    logic [KV_W-1:0] kv = KV_RST;
    int errors = 0;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_YOUNG: young = data;
        CFG_POISSON: poisson = data[PR_W-1:0];
        CFG_KV: kv = data;
        default: ;
      endcase
    endfunction

    function logic [Q_W-1:0] clamp(wide_t x);
      if (&x[127:63] || ~|x[127:63]) return x[63:0];
      return x[127] ? Q_MIN : Q_MAX;
    endfunction

    function void note(in_item_t it);
      wide_t f[3][3];
      wide_t e[3][3];
      wide_t s[3][3];
      wide_t acc, m, pr, div, kk, det, d, el, vt;
      out_item_t r;
      f[0][0] = it.f_00; f[0][1] = it.f_01; f[0][2] = it.f_02;
      f[1][0] = it.f_10; f[1][1] = it.f_11; f[1][2] = it.f_12;
      f[2][0] = it.f_20; f[2][1] = it.f_21; f[2][2] = it.f_22;
      pr = {113'b0, poisson};
      div = (wide_t'(S_ONE) + pr) * (wide_t'(S_ONE) - 2 * pr);
      kk = {76'b0, young, 20'b0};
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          acc = 0;
          for (int k = 0; k < 3; k++) acc += f[k][i] * f[k][j];
          if (i == j) acc -= wide_t'(1) <<< 56;
          e[i][j] = acc >>> 28;
        end
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          if (i == j)
            m = (wide_t'(S_ONE) - pr) * e[i][i]
                + pr * (e[(i + 1) % 3][(i + 1) % 3] + e[(i + 2) % 3][(i + 2) % 3]);
          else
            m = (wide_t'(S_ONE) - 2 * pr) * e[i][j];
          s[i][j] = $signed(clamp((m * kk) / div));
        end
      acc = 0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) acc += s[i][j] * e[i][j];
      el = ((acc >>> 9) * $signed({96'b0, it.point_volume})) >>> 44;
      det = (f[1][1] * f[2][2] - f[1][2] * f[2][1]) * f[0][0]
            - (f[1][0] * f[2][2] - f[1][2] * f[2][0]) * f[0][1]
            + (f[1][0] * f[2][1] - f[1][1] * f[2][0]) * f[0][2];
      d = (det - (wide_t'(1) <<< 84)) >>> 52;
      vt = (d * d * $signed({96'b0, kv})) >>> 33;
      r.energy = clamp(el + vt);
      r.stress_xx = s[0][0][63:0];
      r.stress_yy = s[1][1][63:0];
      r.stress_zz = s[2][2][63:0];
      r.stress_xy = s[0][1][63:0];
      r.stress_yz = s[1][2][63:0];
      r.stress_xz = s[0][2][63:0];
      expected_q.push_back(r);
    endfunction

    function void compare(string name, logic [Q_W-1:0] exp_v, logic [Q_W-1:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check(out_item_t act);
      out_item_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, act);
        return;
      end
      exp_r = expected_q.pop_front();
      compare("energy", exp_r.energy, act.energy);
      compare("stress_xx", exp_r.stress_xx, act.stress_xx);
      compare("stress_yy", exp_r.stress_yy, act.stress_yy);
      compare("stress_zz", exp_r.stress_zz, act.stress_zz);
      compare("stress_xy", exp_r.stress_xy, act.stress_xy);
      compare("stress_yz", exp_r.stress_yz, act.stress_yz);
      compare("stress_xz", exp_r.stress_xz, act.stress_xz);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_item_t item = '0;
  logic done;
  out_item_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  energy_scoreboard sb = new();
  int cycles = 0;
  int idle_pct = 0;

  point_elastic_energy i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item), .done(done),
    .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check(result);
  end

  function automatic in_item_t make_point(int kind);
    logic [31:0] v[10];
    in_item_t p;
    for (int n = 0; n < 10; n++) begin
      case (kind)
        0: v[n] = $urandom();
        1: v[n] = (n % 4 == 0) ? 32'h1000_0000 + $urandom_range(0, 32'h0400_0000) - 32'h0200_0000
                               : $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
        default: v[n] = (n % 4 == 0) ? 32'h1000_0000 : $urandom_range(0, 4095) - 2048;
      endcase
    end
    v[9] = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32'h0400_0000);
    p = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], v[9]};
    return p;
  endfunction

  task automatic send_point(in_item_t p);
    start <= 1'b1;
    item <= p;
    do @(posedge clk); while (busy);
    sb.note(p);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_points(int count);
    for (int n = 0; n < count; n++) send_point(make_point($urandom_range(0, 9) < 7 ? 1 : 0));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_pct = 0;
    send_point(make_point(2));
    send_point('0);
    send_point({{9{32'h7FFF_FFFF}}, 32'hFFFF_FFFF});
    send_point({{9{32'h8000_0000}}, 32'hFFFF_FFFF});
    send_point({32'h1000_0000, 32'h0, 32'h0, 32'h0, 32'h1000_0000, 32'h0, 32'h0, 32'h0,
                32'h1000_0000, 32'h0100_0000});
    send_point({32'h2000_0000, 32'h0800_0000, 32'h0, 32'h0, 32'h0800_0000, 32'hF000_0000,
                32'h0, 32'h0, 32'h1800_0000, 32'hFFFF_FFFF});
    for (int n = 0; n < 6; n++) send_point(make_point(0));
    random_points(310);
    drain();

    write_cfg(CFG_YOUNG, 32'h1);
    write_cfg(CFG_POISSON, 32'h1);
    write_cfg(CFG_KV, 32'hFFFF_FFFF);
    idle_pct = 67;
    send_point({{9{32'h7FFF_FFFF}}, 32'hFFFF_FFFF});
    random_points(320);
    drain();

    write_cfg(CFG_YOUNG, 32'hFFFF_FFFF);
    write_cfg(CFG_POISSON, 32'h7FFF);
    write_cfg(CFG_KV, 32'h0);
    idle_pct = 14;
    send_point({{9{32'h8000_0000}}, 32'hFFFF_FFFF});
    random_points(320);
    drain();

    write_cfg(CFG_POISSON, 32'hFFFF_8000);
    write_cfg(CFG_KV, 32'h0001_0000);
    write_cfg(2'd3, 32'h1234_5678);
    idle_pct = 0;
    send_point(make_point(2));
    random_points(320);
    drain();

    for (int r = 0; r < 2; r++) begin
      write_cfg(CFG_YOUNG, $urandom());
      write_cfg(CFG_POISSON, $urandom_range(1, 32767));
      write_cfg(CFG_KV, $urandom());
      idle_pct = r ? 67 : 14;
      random_points(320);
      drain();
    end

    if (sb.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
